// ===== rtl/acctilt_pkg.sv =====
`default_nettype none
package acctilt_pkg;
	localparam int TABLE_LEN = 24;
	localparam int ANG_W = 32;
	localparam int DEG_MAX = 90;
	localparam int FOLD_DEG = 180;

	function automatic logic [ANG_W-1:0] atan_entry(input int idx);
		logic [ANG_W-1:0] r;
		begin
			case (idx)
				0: r = 32'd2949120;
				1: r = 32'd1740967;
				2: r = 32'd919879;
				3: r = 32'd466945;
				4: r = 32'd234379;
				5: r = 32'd117304;
				6: r = 32'd58666;
				7: r = 32'd29335;
				8: r = 32'd14668;
				9: r = 32'd7334;
				10: r = 32'd3667;
				11: r = 32'd1833;
				12: r = 32'd917;
				13: r = 32'd458;
				14: r = 32'd229;
				15: r = 32'd115;
				16: r = 32'd57;
				17: r = 32'd29;
				18: r = 32'd14;
				19: r = 32'd7;
				20: r = 32'd4;
				21: r = 32'd2;
				22: r = 32'd1;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	typedef struct packed {
		logic       bypass;
		logic       degen;
		logic       neg;
		logic [7:0] fixed_deg;
	} acctilt_flags_t;
endpackage
`default_nettype wire

// ===== rtl/acctilt_isqrt.sv =====
`default_nettype none
// Pipelined restoring square root, one result bit per stage.
module acctilt_isqrt #(
	parameter int IN_W = 40,
	parameter int OUT_W = 20,
	parameter int SIDE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [IN_W-1:0]   radicand,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic [OUT_W-1:0]       root,
	output logic [SIDE_W-1:0]      side_out
);
	logic [IN_W-1:0]   rem_q  [0:OUT_W];
	logic [OUT_W-1:0]  res_q  [0:OUT_W];
	logic [SIDE_W-1:0] side_q [0:OUT_W];

	always_comb begin
		rem_q[0] = radicand;
		res_q[0] = '0;
		side_q[0] = side_in;
	end

	for (genvar k = 0; k < OUT_W; k++) begin : g_st
		localparam int SH = 2*(OUT_W-1-k);
		logic [IN_W+1:0] trial;
		logic [IN_W+1:0] rem_ext;
		logic [IN_W-1:0] rem_nx;
		logic [OUT_W-1:0] res_nx;
		logic [IN_W-1:0] rem_r;
		logic [OUT_W-1:0] res_r;
		logic [SIDE_W-1:0] side_r;
		always_comb begin
			// trial subtrahend is (4*root_so_far + 1) at this bit pair
			trial = ({{(IN_W+2-OUT_W){1'b0}}, res_q[k]} << 2 | (IN_W+2)'(1)) << SH;
			rem_ext = {2'b00, rem_q[k]};
			if (rem_ext >= trial) begin
				rem_nx = IN_W'(rem_ext - trial);
				res_nx = (res_q[k] << 1) | OUT_W'(1);
			end else begin
				rem_nx = rem_q[k];
				res_nx = res_q[k] << 1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_r <= rem_nx;
				res_r <= res_nx;
				side_r <= side_q[k];
			end
		end
		always_comb begin
			rem_q[k+1] = rem_r;
			res_q[k+1] = res_r;
			side_q[k+1] = side_r;
		end
	end

	assign root = res_q[OUT_W];
	assign side_out = side_q[OUT_W];
endmodule
`default_nettype wire

// ===== rtl/acctilt_lane.sv =====
`default_nettype none
// One angle lane: squares, sqrt, vectoring CORDIC, truncation.
module acctilt_lane #(
	parameter int SAMPLE_BITS = 12,
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [SAMPLE_BITS-1:0] a,
	input  wire logic signed [SAMPLE_BITS-1:0] b,
	input  wire logic signed [SAMPLE_BITS-1:0] c,
	output logic signed [7:0]                  angle,
	output logic                               degen
);
	import acctilt_pkg::*;

	localparam int SQ_W = 2*SAMPLE_BITS;
	localparam int DSQ_W = SQ_W + 1;
	localparam int RAD_W = DSQ_W + 16 + ((DSQ_W + 16) % 2);
	localparam int RT_W = RAD_W / 2;
	localparam int CW = RT_W + 4;
	localparam int NST = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
	localparam int SIDE_W = SAMPLE_BITS + 1 + 1 + 1 + 8;
	localparam int FL_W = $bits(acctilt_flags_t);

	// stage 1: squares
	logic [SQ_W-1:0] bsq_s1, csq_s1;
	logic signed [SAMPLE_BITS-1:0] a_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			bsq_s1 <= SQ_W'(b) * SQ_W'(b);
			csq_s1 <= SQ_W'(c) * SQ_W'(c);
			a_s1 <= a;
		end
	end

	// stage 2: sum and special-case flags
	logic [DSQ_W-1:0] dsq_s2;
	logic [SAMPLE_BITS-1:0] mag_s2;
	acctilt_flags_t fl_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			dsq_s2 <= DSQ_W'(bsq_s1) + DSQ_W'(csq_s1);
			mag_s2 <= a_s1[SAMPLE_BITS-1] ? SAMPLE_BITS'(-a_s1) : SAMPLE_BITS'(a_s1);
			fl_s2.neg <= a_s1[SAMPLE_BITS-1];
			fl_s2.bypass <= (a_s1 == '0) || ((bsq_s1 == '0) && (csq_s1 == '0));
			fl_s2.degen <= (a_s1 == '0) && (bsq_s1 == '0) && (csq_s1 == '0);
			fl_s2.fixed_deg <= (a_s1 == '0) ? 8'd0 : 8'(DEG_MAX);
		end
	end

	logic [RT_W-1:0] root;
	logic [SIDE_W-1:0] side_out;
	acctilt_isqrt #(.IN_W(RAD_W), .OUT_W(RT_W), .SIDE_W(SIDE_W)) u_sqrt (
		.clk(clk), .en(en),
		.radicand(RAD_W'(dsq_s2) << 16),
		.side_in({mag_s2, fl_s2.bypass, fl_s2.degen, fl_s2.neg, fl_s2.fixed_deg}),
		.root(root), .side_out(side_out)
	);

	logic signed [CW-1:0] x_c [0:NST];
	logic signed [CW-1:0] y_c [0:NST];
	logic signed [ANG_W-1:0] z_c [0:NST];
	logic [SIDE_W-1:0] sd_c [0:NST];

	always_comb begin
		x_c[0] = CW'(root);
		y_c[0] = CW'({side_out[SIDE_W-1 -: SAMPLE_BITS], 8'd0});
		z_c[0] = '0;
		sd_c[0] = side_out;
	end

	for (genvar i = 0; i < NST; i++) begin : g_cor
		logic signed [CW-1:0] xn, yn, xr, yr;
		logic signed [ANG_W-1:0] zn, zr;
		logic [SIDE_W-1:0] sr;
		always_comb begin
			xn = x_c[i];
			yn = y_c[i];
			zn = z_c[i];
			if (y_c[i] > 0) begin
				xn = x_c[i] + (y_c[i] >>> i);
				yn = y_c[i] - (x_c[i] >>> i);
				zn = z_c[i] + $signed(atan_entry(i));
			end else if (y_c[i] < 0) begin
				xn = x_c[i] - (y_c[i] >>> i);
				yn = y_c[i] + (x_c[i] >>> i);
				zn = z_c[i] - $signed(atan_entry(i));
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				xr <= xn;
				yr <= yn;
				zr <= zn;
				sr <= sd_c[i];
			end
		end
		always_comb begin
			x_c[i+1] = xr;
			y_c[i+1] = yr;
			z_c[i+1] = zr;
			sd_c[i+1] = sr;
		end
	end

	// final: truncate toward zero, clamp 0..90, use the fixed angle on bypass, apply sign
	logic signed [ANG_W-1:0] zf;
	logic [ANG_W-1:0] zabs;
	logic [ANG_W-17:0] dmag;
	logic [7:0] dsat;
	acctilt_flags_t fo;
	always_comb begin
		zf = z_c[NST];
		fo = acctilt_flags_t'(sd_c[NST][FL_W-1:0]);
		zabs = zf[ANG_W-1] ? ANG_W'(-zf) : ANG_W'(zf);
		dmag = zabs[ANG_W-1:16];
		if (zf[ANG_W-1]) dsat = 8'd0;
		else if (dmag > (ANG_W-16)'(DEG_MAX)) dsat = 8'(DEG_MAX);
		else dsat = dmag[7:0];
		if (fo.bypass) dsat = fo.fixed_deg;
		angle = fo.neg ? -$signed(dsat) : $signed(dsat);
		degen = fo.degen;
	end
endmodule
`default_nettype wire

// ===== rtl/accel_tilt_angles_top.sv =====
`default_nettype none
// channel | signals                                        | dir
// in      | in_valid/in_ready, accel_x/y/z                 | sink
// out     | out_valid/out_ready, tilt_x/y/z_deg, degenerate | source
// One word per cycle sustained while the output is taken; path: squares, sum, sqrt, CORDIC, output register.
// Three lanes (x, y, z) run in lockstep; the merge stage applies the fold.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears the valid bits of every stage; payload is not reset.
module accel_tilt_angles_top #(
	parameter int SAMPLE_BITS = 12,
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] accel_x,
	input  wire logic signed [SAMPLE_BITS-1:0] accel_y,
	input  wire logic signed [SAMPLE_BITS-1:0] accel_z,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [9:0]                  tilt_x_deg,
	output logic signed [9:0]                  tilt_y_deg,
	output logic signed [7:0]                  tilt_z_deg,
	output logic                               degenerate
);
	import acctilt_pkg::*;

	localparam int DSQ_W = 2*SAMPLE_BITS + 1;
	localparam int RAD_W = DSQ_W + 16 + ((DSQ_W + 16) % 2);
	localparam int NST = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
	localparam int LAT = 2 + RAD_W/2 + NST;

	logic en;
	logic [LAT-1:0] vld_q;
	// stall all stages together only when output holds an untaken word
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	logic signed [7:0] ax, ay, az;
	logic dx, dy, dz;
	acctilt_lane #(.SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lx (
		.clk(clk), .en(en), .a(accel_x), .b(accel_y), .c(accel_z),
		.angle(ax), .degen(dx));
	acctilt_lane #(.SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_ly (
		.clk(clk), .en(en), .a(accel_y), .b(accel_x), .c(accel_z),
		.angle(ay), .degen(dy));
	acctilt_lane #(.SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lz (
		.clk(clk), .en(en), .a(accel_z), .b(accel_x), .c(accel_y),
		.angle(az), .degen(dz));

	// merge: fold x and y when z tilt is negative
	logic out_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= vld_q[LAT-1];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tilt_x_deg <= az[7] ? 10'(FOLD_DEG) - 10'(ax) : 10'(ax);
			tilt_y_deg <= az[7] ? 10'(FOLD_DEG) - 10'(ay) : 10'(ay);
			tilt_z_deg <= az;
			degenerate <= dx | dy | dz;
		end
	end
	assign out_valid = out_v_q;

`ifndef SYNTH
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tilt_x_deg))
		else $error("output word changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while pipeline stalled");
	a_zrange: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tilt_z_deg <= 8'sd90) && (tilt_z_deg >= -8'sd90))
		else $error("z tilt out of range");
`endif
endmodule
`default_nettype wire
